### design/assert_macros.svh
// Assertion macros for the checker file of the project.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/flpf_pkg.sv
// Widths, reset values and a helper function of the fixed-length packet framer.
// Depends on nothing; imported by the framer and its checker.
package flpf_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned IDX_W  = 7;
   localparam int unsigned SUM_W  = 16;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CNT_W  = 16;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd200;
   localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

   typedef logic [CNT_W-1:0] count_type;

   function automatic count_type sat_inc(input count_type value);
      sat_inc = (value == CNT_MAX) ? value : count_type'(value + 1'b1);
   endfunction

endpackage

### design/fixed_length_packet_framer.sv
// Fixed-length packet framer: header hunt, 16-bit additive checksum, timestamp.
// Depends on flpf_pkg for widths, reset values and the saturating counter.
//
// Usage: received bytes enter on the req_ channel (valid/ready), one per transfer.
// While hunting, every byte other than the header byte counts as a header error.
// A header opens a frame of FRAME_LENGTH bytes; the last byte of a frame produces
// one transfer on the rsp_ channel with the checksum verdict, the big-endian
// timestamp at TIME_OFFSET, the interval since the last good frame, both
// checksums and the two saturating error counts. Other bytes produce nothing.
// The header byte is set through csr_wr_en/csr_wr_data; the user must write it
// only while the block is idle, and the block itself does not enforce this.
// A byte is held in the input register and processed from there; results are registered.
// Throughput: one byte per cycle, set by the single update stage, outside stalls.
// Reset clears the frame state, both error counts and the last good timestamp,
// and sets the header byte to 200.
// When the receiver stalls, bytes that end no frame keep flowing; a byte that
// ends a frame waits in the input register until the pending result is taken.
module fixed_length_packet_framer
   import flpf_pkg::*;
#(
   parameter int unsigned FRAME_LENGTH = 67,
   parameter int unsigned TIME_OFFSET  = 61
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_frame_good,
   output logic [TIME_W-1:0] rsp_frame_timestamp,
   output logic [TIME_W-1:0] rsp_tick_interval,
   output logic [SUM_W-1:0]  rsp_received_checksum,
   output logic [SUM_W-1:0]  rsp_computed_checksum,
   output logic [CNT_W-1:0]  rsp_header_errors,
   output logic [CNT_W-1:0]  rsp_checksum_errors
);

   localparam logic [IDX_W:0] FRAME_LEN_EXT  = (IDX_W+1)'(FRAME_LENGTH);
   localparam logic [IDX_W:0] TIME_FIRST_EXT = (IDX_W+1)'(TIME_OFFSET);
   localparam logic [IDX_W:0] TIME_LAST_EXT  = (IDX_W+1)'(TIME_OFFSET + 3);

   logic [BYTE_W-1:0] header_ff, header_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;

   logic              reading_ff, reading_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] chk_high_ff, chk_high_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   count_type         hdr_cnt_ff, hdr_cnt_in;
   count_type         chk_cnt_ff, chk_cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              good_ff, good_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;
   logic [TIME_W-1:0] interval_ff, interval_in;
   logic [SUM_W-1:0]  rx_sum_ff, rx_sum_in;
   logic [SUM_W-1:0]  calc_sum_ff, calc_sum_in;
   logic [CNT_W-1:0]  hdr_out_ff, hdr_out_in;
   logic [CNT_W-1:0]  chk_out_ff, chk_out_in;

   logic [IDX_W:0]    index_ext;
   logic              ends_frame;
   logic              process;
   logic              load_rsp;
   logic [SUM_W-1:0]  rx_sum;

   assign index_ext  = {1'b0, index_ff};
   assign ends_frame = reading_ff && ((index_ext + 1'b1) >= FRAME_LEN_EXT);
   assign process    = in_valid_ff && (!ends_frame || !rsp_valid_ff || rsp_ready);
   assign load_rsp   = process && ends_frame;
   assign req_ready  = !in_valid_ff || process;
   assign rx_sum     = {chk_high_ff, in_byte_ff};

   always_comb begin
      header_in    = csr_wr_en ? csr_wr_data : header_ff;
      in_valid_in  = (req_valid && req_ready) ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      in_byte_in   = (req_valid && req_ready) ? req_rx_byte : in_byte_ff;

      reading_in   = reading_ff;
      index_in     = index_ff;
      sum_in       = sum_ff;
      chk_high_in  = chk_high_ff;
      time_in      = time_ff;
      prev_time_in = prev_time_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      chk_cnt_in   = chk_cnt_ff;

      if (process) begin
         if (!reading_ff) begin
            index_in = '0;
            if (in_byte_ff == header_ff) begin
               reading_in  = 1'b1;
               sum_in      = SUM_W'(in_byte_ff);
               chk_high_in = '0;
               time_in     = '0;
               index_in    = IDX_W'(1);
            end else begin
               hdr_cnt_in = sat_inc(hdr_cnt_ff);
            end
         end else begin
            if ((index_ext + 2'd2) < FRAME_LEN_EXT) begin
               sum_in = sum_ff + SUM_W'(in_byte_ff);
            end
            if (index_ext >= TIME_FIRST_EXT && index_ext <= TIME_LAST_EXT) begin
               time_in = {time_ff[TIME_W-BYTE_W-1:0], in_byte_ff};
            end
            if ((index_ext + 2'd2) == FRAME_LEN_EXT) begin
               chk_high_in = in_byte_ff;
            end
            if (ends_frame) begin
               reading_in = 1'b0;
               index_in   = '0;
               if (rx_sum == sum_in) begin
                  prev_time_in = time_in;
               end else begin
                  chk_cnt_in = sat_inc(chk_cnt_ff);
               end
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
      end

      good_in      = (rx_sum == sum_in);
      stamp_in     = time_in;
      interval_in  = time_in - prev_time_ff;
      rx_sum_in    = rx_sum;
      calc_sum_in  = sum_in;
      hdr_out_in   = hdr_cnt_in;
      chk_out_in   = chk_cnt_in;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= HEADER_RESET;
         in_valid_ff  <= 1'b0;
         reading_ff   <= 1'b0;
         index_ff     <= '0;
         sum_ff       <= '0;
         chk_high_ff  <= '0;
         time_ff      <= '0;
         prev_time_ff <= '0;
         hdr_cnt_ff   <= '0;
         chk_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         in_valid_ff  <= in_valid_in;
         reading_ff   <= reading_in;
         index_ff     <= index_in;
         sum_ff       <= sum_in;
         chk_high_ff  <= chk_high_in;
         time_ff      <= time_in;
         prev_time_ff <= prev_time_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         chk_cnt_ff   <= chk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (load_rsp) begin
         good_ff     <= good_in;
         stamp_ff    <= stamp_in;
         interval_ff <= interval_in;
         rx_sum_ff   <= rx_sum_in;
         calc_sum_ff <= calc_sum_in;
         hdr_out_ff  <= hdr_out_in;
         chk_out_ff  <= chk_out_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_good        = good_ff;
   assign rsp_frame_timestamp   = stamp_ff;
   assign rsp_tick_interval     = interval_ff;
   assign rsp_received_checksum = rx_sum_ff;
   assign rsp_computed_checksum = calc_sum_ff;
   assign rsp_header_errors     = hdr_out_ff;
   assign rsp_checksum_errors   = chk_out_ff;

endmodule

### design/flpf_checker.sv
// Port-level checker for the fixed-length packet framer, bound to the top level.
// Depends on flpf_pkg for widths and on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module flpf_checker
   import flpf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_frame_good,
   input logic [TIME_W-1:0] rsp_frame_timestamp,
   input logic [SUM_W-1:0]  rsp_received_checksum,
   input logic [SUM_W-1:0]  rsp_computed_checksum,
   input logic [CNT_W-1:0]  rsp_checksum_errors
);

   // A result never shows up in the cycle right after reset.
   `ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // The verdict must agree with the two checksums it reports.
   `ASSERT_RST(a_verdict_matches, clock, reset,
      rsp_valid |-> (rsp_frame_good == (rsp_received_checksum == rsp_computed_checksum)),
      "verdict disagrees with checksums")

   // A bad frame has already been counted in the reported error count.
   `ASSERT_RST(a_bad_frame_counted, clock, reset,
      (rsp_valid && !rsp_frame_good) |-> (rsp_checksum_errors != '0),
      "bad frame not counted")

   // A stalled result keeps its timestamp until the transfer completes.
   `ASSERT_RST(a_rsp_held, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_frame_timestamp)),
      "stalled result dropped or changed")

endmodule

bind fixed_length_packet_framer flpf_checker u_flpf_checker (.*);
